// ----- hdl/radix_integer_text_parser_unit_macros.svh -----
// assertion helpers for the checker file
`ifndef RADIX_INTEGER_TEXT_PARSER_UNIT_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define RITP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ritp check failed");

// next-cycle implication, held off during reset
`define RITP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ritp check failed");

`endif

// ----- hdl/ritp_pkg.sv -----
package ritp_pkg;

  // width of the consumed-byte counter
  localparam int unsigned CountBits = 16;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RadixW = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned OutCntW = 16;

  // character codes
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharUpA   = 8'h41;
  localparam logic [ByteW-1:0] CharUpZ   = 8'h5A;
  localparam logic [ByteW-1:0] CharLoA   = 8'h61;
  localparam logic [ByteW-1:0] CharLoZ   = 8'h7A;
  localparam logic [ByteW-1:0] UpperBias = 8'd55;
  localparam logic [ByteW-1:0] LowerBias = 8'd87;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;

  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [RadixW-1:0] RadixDec = 6'd10;

  // register indexes on the configuration port
  typedef enum logic [IdxW-1:0] {
    RegPlus   = 3'd0,
    RegMinus  = 3'd1,
    RegFill   = 3'd2,
    RegRadix  = 3'd3,
    RegFillMd = 3'd4,
    RegCase   = 3'd5
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    FillLeft     = 2'd0,
    FillRight    = 2'd1,
    FillInternal = 2'd2
  } fill_mode_e;

  typedef enum logic [ModeW-1:0] {
    CaseEither = 2'd0,
    CaseLower  = 2'd1,
    CaseUpper  = 2'd2
  } letter_case_e;

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhDigits = 2'd1,
    PhIfill  = 2'd2
  } phase_e;

  typedef struct packed {
    logic              ok;
    logic [RadixW-1:0] val;
  } digit_t;

  // digit value of a byte in the given radix and letter case mode
  function automatic digit_t digit_of(logic [ByteW-1:0] b, logic [RadixW-1:0] radix,
                                      logic [ModeW-1:0] lcase);
    digit_t          res;
    logic [ByteW-1:0] d;
    logic            hit;
    d   = '0;
    hit = 1'b0;
    if (b >= CharZero && b <= CharNine) begin
      d   = b - CharZero;
      hit = 1'b1;
    end else if (radix > RadixDec && b >= CharUpA && b <= CharUpZ && lcase != CaseLower) begin
      d   = b - UpperBias;
      hit = 1'b1;
    end else if (radix > RadixDec && b >= CharLoA && b <= CharLoZ &&
                 (lcase == CaseEither || lcase == CaseLower)) begin
      d   = b - LowerBias;
      hit = 1'b1;
    end
    res.ok  = hit && (d < ByteW'(radix));
    res.val = d[RadixW-1:0];
    return res;
  endfunction

  // report width of the count, saturated at its all-ones value
  function automatic logic [OutCntW-1:0] sat_count(logic [CountBits-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? '1 : w[OutCntW-1:0];
  endfunction

endpackage

// ----- hdl/radix_integer_text_parser_unit.sv -----
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------------------------
// text in  | input     | in_valid_i / in_ready_o   | text_byte_i
// result   | output    | out_valid_o / out_ready_i | parsed_value_o, bytes_consumed_o, end_byte_o
// config   | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// one byte per cycle while no terminator waits on a full output register: a byte
// sits in the input register, where the 64 x 6 multiply-accumulate by the radix
// decides it; a terminator loads the output register on the same edge that takes
// it from the input register.
// non-terminating bytes leave no result and pass even while a result waits.
// a terminator waits in the input register while the output register is full.
// reset clears the configuration to its defaults and the parse to a fresh number.
module radix_integer_text_parser_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ritp_pkg::ByteW-1:0]           text_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ritp_pkg::ValueW-1:0]   parsed_value_o,
  output logic [ritp_pkg::OutCntW-1:0]         bytes_consumed_o,
  output logic [ritp_pkg::ByteW-1:0]           end_byte_o,
  input  logic                                 cfg_we_i,
  input  logic [ritp_pkg::IdxW-1:0]            cfg_index_i,
  input  logic [ritp_pkg::ByteW-1:0]           cfg_data_i
);

  // configuration registers
  logic [ritp_pkg::ByteW-1:0]  plus_q, minus_q, fill_q;
  logic [ritp_pkg::RadixW-1:0] radix_q;
  logic [ritp_pkg::ModeW-1:0]  fill_mode_q, case_q;

  // input register
  logic                       in_vld_q;
  logic [ritp_pkg::ByteW-1:0] byte_q;

  // parse state
  ritp_pkg::phase_e              phase_q, phase_d;
  logic                          neg_q, neg_d;
  logic [ritp_pkg::ValueW-1:0]   acc_q, acc_d;
  logic [ritp_pkg::CountBits-1:0] cnt_q, cnt_d;

  // output register
  logic                          out_vld_q;
  logic [ritp_pkg::ValueW-1:0]   val_q;
  logic [ritp_pkg::OutCntW-1:0]  ocnt_q;
  logic [ritp_pkg::ByteW-1:0]    oend_q;

  logic                       take, term, advance, out_free;
  logic [ritp_pkg::ByteW-1:0] fill_eff;
  logic                       is_fill, is_minus, is_plus, fm_left, fm_int;
  ritp_pkg::phase_e           after_sign;
  ritp_pkg::digit_t           dig;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_q      <= ritp_pkg::CharPlus;
      minus_q     <= ritp_pkg::CharMinus;
      fill_q      <= ritp_pkg::CharSpace;
      radix_q     <= ritp_pkg::RadixDec;
      fill_mode_q <= ritp_pkg::FillLeft;
      case_q      <= ritp_pkg::CaseEither;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ritp_pkg::RegPlus:   plus_q  <= cfg_data_i;
        ritp_pkg::RegMinus:  minus_q <= cfg_data_i;
        ritp_pkg::RegFill:   fill_q  <= cfg_data_i;
        ritp_pkg::RegRadix: begin
          if (cfg_data_i[ritp_pkg::RadixW-1:0] >= ritp_pkg::RadixMin &&
              cfg_data_i[ritp_pkg::RadixW-1:0] <= ritp_pkg::RadixMax) begin
            radix_q <= cfg_data_i[ritp_pkg::RadixW-1:0];
          end
        end
        ritp_pkg::RegFillMd: fill_mode_q <= cfg_data_i[ritp_pkg::ModeW-1:0];
        ritp_pkg::RegCase:   case_q      <= cfg_data_i[ritp_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  // byte classification
  assign fill_eff   = (fill_q == '0) ? ritp_pkg::CharZero : fill_q;
  assign is_fill    = (byte_q == fill_eff);
  assign is_minus   = (minus_q != '0) && (byte_q == minus_q);
  assign is_plus    = (plus_q != '0) && (byte_q == plus_q);
  assign fm_left    = (fill_mode_q == ritp_pkg::FillLeft);
  assign fm_int     = (fill_mode_q == ritp_pkg::FillInternal);
  assign after_sign = fm_int ? ritp_pkg::PhIfill : ritp_pkg::PhDigits;
  assign dig        = ritp_pkg::digit_of(byte_q, radix_q, case_q);

  // phase decision and accumulate for the word in the input register
  always_comb begin
    take    = 1'b0;
    term    = 1'b0;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (phase_q == ritp_pkg::PhStart && fm_left && is_fill) begin
      take = 1'b1;
    end else if (phase_q == ritp_pkg::PhStart && (is_minus || is_plus)) begin
      take    = 1'b1;
      neg_d   = neg_q | is_minus;
      phase_d = after_sign;
    end else if ((phase_q == ritp_pkg::PhIfill || (phase_q == ritp_pkg::PhStart && fm_int))
                 && is_fill) begin
      take    = 1'b1;
      phase_d = ritp_pkg::PhIfill;
    end else if (dig.ok) begin
      take    = 1'b1;
      phase_d = ritp_pkg::PhDigits;
      acc_d   = acc_q * ritp_pkg::ValueW'(radix_q) + ritp_pkg::ValueW'(dig.val);
    end else begin
      term = 1'b1;
    end
  end

  // counter saturates at all ones
  always_comb begin
    cnt_d = cnt_q;
    if (take && cnt_q != '1) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // handshake: a terminator needs room in the output register
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && (!term || out_free);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ritp_pkg::PhStart;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (advance) begin
      if (term) begin
        phase_q <= ritp_pkg::PhStart;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && term) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (advance && term) begin
      val_q  <= neg_q ? (ritp_pkg::ValueW'(0) - acc_q) : acc_q;
      ocnt_q <= ritp_pkg::sat_count(cnt_q);
      oend_q <= byte_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign parsed_value_o   = val_q;
  assign bytes_consumed_o = ocnt_q;
  assign end_byte_o       = oend_q;

endmodule

// ----- hdl/ritp_checker.sv -----
`include "radix_integer_text_parser_unit_macros.svh"

module ritp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [ritp_pkg::ValueW-1:0]   parsed_value_o,
  input logic [ritp_pkg::OutCntW-1:0]         bytes_consumed_o,
  input logic [ritp_pkg::ByteW-1:0]           end_byte_o
);

  localparam int unsigned WordW = ritp_pkg::ValueW + ritp_pkg::OutCntW + ritp_pkg::ByteW;

  logic             out_stall;
  logic             empty_word;
  logic [WordW-1:0] out_word;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign empty_word = out_valid_o && (bytes_consumed_o == '0);
  assign out_word   = {parsed_value_o, bytes_consumed_o, end_byte_o};

  // a stalled result keeps its word
  `RITP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word))

  // nothing consumed means nothing accumulated and no sign
  `RITP_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, empty_word, parsed_value_o == '0)

  // no result straight out of reset
  `RITP_ASSERT_IMP(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), !out_valid_o)

  // a result needs a byte taken earlier, so reset was already released before it
  `RITP_ASSERT_IMP(a_out_cause, clk_i, rst_ni, $rose(out_valid_o), $past(rst_ni) && $past(rst_ni, 2))

endmodule

bind radix_integer_text_parser_unit ritp_checker u_ritp_checker (.*);

// ----- test/radix_integer_text_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module radix_integer_text_parser_unit_tb;
  import ritp_pkg::*;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 150;

  // register indexes with no register behind them
  localparam logic [IdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [IdxW-1:0] RegSpareHi = 3'd7;
  // mode codes outside the named set
  localparam logic [ModeW-1:0] FillSpare = 2'd3;
  localparam logic [ModeW-1:0] CaseSpare = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [OutCntW-1:0]       count;
    logic [ByteW-1:0]         term;
  } parse_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [ByteW-1:0]          text_byte_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [ValueW-1:0]  parsed_value_o;
  logic [OutCntW-1:0]        bytes_consumed_o;
  logic [ByteW-1:0]          end_byte_o;
  logic                      cfg_we_i = 1'b0;
  logic [IdxW-1:0]           cfg_index_i = '0;
  logic [ByteW-1:0]          cfg_data_i = '0;

  // shadow copy of the registers
  logic [ByteW-1:0]  cfg_plus = CharPlus;
  logic [ByteW-1:0]  cfg_minus = CharMinus;
  logic [ByteW-1:0]  cfg_fill = CharSpace;
  logic [RadixW-1:0] cfg_radix = RadixDec;
  logic [ModeW-1:0]  cfg_fill_mode = FillLeft;
  logic [ModeW-1:0]  cfg_case = CaseEither;

  // shadow copy of the number being scanned
  phase_e            scan_phase = PhStart;
  logic              scan_negative = 1'b0;
  logic [ValueW-1:0] scan_acc = '0;
  logic [CountBits-1:0] scan_count = '0;

  parse_result_t expected_parses[$];
  parse_result_t head_parse;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  bit            idle_on = 1'b1;
  bit            hold_results = 1'b0;

  radix_integer_text_parser_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .parsed_value_o   (parsed_value_o),
    .bytes_consumed_o (bytes_consumed_o),
    .end_byte_o       (end_byte_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mismatch reporting
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // digit value of a byte under the shadow registers, -1 if none
  function automatic int digit_value(logic [ByteW-1:0] b);
    int d;
    d = -1;
    if (b >= CharZero && b <= CharNine) begin
      d = int'(b) - int'(CharZero);
    end else if (cfg_radix > RadixDec && b >= CharUpA && b <= CharUpZ &&
                 cfg_case != CaseLower) begin
      d = int'(b) - int'(UpperBias);
    end else if (cfg_radix > RadixDec && b >= CharLoA && b <= CharLoZ &&
                 (cfg_case == CaseEither || cfg_case == CaseLower)) begin
      d = int'(b) - int'(LowerBias);
    end
    if (d >= int'(cfg_radix)) d = -1;
    return d;
  endfunction

  function automatic void count_byte();
    if (scan_count != '1) scan_count = scan_count + 1'b1;
  endfunction

  // advance the scan by one text byte, queueing a result on a terminator
  function automatic void parse_text_byte(logic [ByteW-1:0] b);
    logic [ByteW-1:0] fill_eff;
    int               d;
    parse_result_t    res;
    fill_eff = (cfg_fill == '0) ? CharZero : cfg_fill;
    if (scan_phase == PhStart) begin
      if (cfg_fill_mode == FillLeft && b == fill_eff) begin
        count_byte();
        return;
      end
      if (cfg_fill_mode == FillInternal) scan_phase = PhIfill;
      else scan_phase = PhDigits;
      if (cfg_minus != '0 && b == cfg_minus) begin
        scan_negative = 1'b1;
        count_byte();
        return;
      end
      if (cfg_plus != '0 && b == cfg_plus) begin
        count_byte();
        return;
      end
    end
    if (scan_phase == PhIfill) begin
      if (b == fill_eff) begin
        count_byte();
        return;
      end
      scan_phase = PhDigits;
    end
    d = digit_value(b);
    if (d >= 0) begin
      scan_acc = scan_acc * ValueW'(cfg_radix) + ValueW'(d);
      count_byte();
      return;
    end
    res.value = scan_negative ? (ValueW'(0) - scan_acc) : scan_acc;
    res.count = (32'(scan_count) > 32'h0000_FFFF) ? '1 : OutCntW'(scan_count);
    res.term  = b;
    expected_parses.push_back(res);
    scan_phase    = PhStart;
    scan_negative = 1'b0;
    scan_acc      = '0;
    scan_count    = '0;
  endfunction

  // offer one text word and wait for it to be taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    text_byte_i <= b;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    parse_text_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop offering, let every result out and the last bytes settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_parses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write; the enable stays high until released
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      RegPlus:   cfg_plus = val;
      RegMinus:  cfg_minus = val;
      RegFill:   cfg_fill = val;
      RegRadix: begin
        if (val[RadixW-1:0] >= RadixMin && val[RadixW-1:0] <= RadixMax)
          cfg_radix = val[RadixW-1:0];
      end
      RegFillMd: cfg_fill_mode = val[ModeW-1:0];
      RegCase:   cfg_case = val[ModeW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(input logic [ByteW-1:0] plus, input logic [ByteW-1:0] minus,
                             input logic [ByteW-1:0] fill, input logic [ByteW-1:0] radix,
                             input logic [ByteW-1:0] mode, input logic [ByteW-1:0] lcase);
    write_reg(RegPlus, plus);
    write_reg(RegMinus, minus);
    write_reg(RegFill, fill);
    write_reg(RegRadix, radix);
    write_reg(RegFillMd, mode);
    write_reg(RegCase, lcase);
    cfg_release();
  endtask

  // a digit character for value d under the shadow letter case
  function automatic logic [ByteW-1:0] digit_char(int unsigned d);
    if (d < 10) return CharZero + ByteW'(d);
    if (cfg_case == CaseLower || (cfg_case == CaseEither && $urandom_range(0, 1) == 1))
      return CharLoA + ByteW'(d - 10);
    return CharUpA + ByteW'(d - 10);
  endfunction

  // a well-formed number with random content and a random terminator
  task automatic send_number(output int unsigned cnt);
    logic [ByteW-1:0] fill_eff;
    logic [ByteW-1:0] sign_b;
    int unsigned      n_digits;
    cnt      = 0;
    fill_eff = (cfg_fill == '0) ? CharZero : cfg_fill;
    if (cfg_fill_mode == FillLeft) begin
      repeat ($urandom_range(0, 3)) begin
        send_byte(fill_eff);
        cnt++;
      end
    end
    if ($urandom_range(0, 2) != 0) begin
      sign_b = ($urandom_range(0, 1) == 0) ? cfg_minus : cfg_plus;
      if (sign_b != '0) begin
        send_byte(sign_b);
        cnt++;
      end
    end
    if (cfg_fill_mode == FillInternal) begin
      repeat ($urandom_range(0, 2)) begin
        send_byte(fill_eff);
        cnt++;
      end
    end
    case ($urandom_range(0, 15))
      0:       n_digits = 0;
      1, 2:    n_digits = $urandom_range(7, 24);
      default: n_digits = $urandom_range(1, 6);
    endcase
    repeat (n_digits) begin
      send_byte(digit_char($urandom_range(0, int'(cfg_radix) - 1)));
      cnt++;
    end
    case ($urandom_range(0, 5))
      0:       send_byte(8'h00);
      1:       send_byte(",");
      2:       send_byte(";");
      default: send_byte(ByteW'($urandom_range(0, 255)));
    endcase
    cnt++;
  endtask

  // defaults after reset, empty parses and the zero byte
  task automatic test_reset_defaults();
    send_text("  -42,");
    send_text("+0");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("9a");
    wait_idle();
  endtask

  // register extremes, ignored writes and value wrap
  task automatic test_register_extremes();
    write_reg(RegPlus, 8'hFF);
    write_reg(RegMinus, 8'h00);
    write_reg(RegFill, 8'h00);
    write_reg(RegRadix, ByteW'(RadixMax));
    write_reg(RegFillMd, ByteW'(FillInternal));
    write_reg(RegCase, ByteW'(CaseEither));
    write_reg(RegSpareLo, 8'hFF);
    write_reg(RegSpareHi, 8'h55);
    // out-of-range radix values leave the base alone
    write_reg(RegRadix, 8'd0);
    write_reg(RegRadix, 8'd1);
    write_reg(RegRadix, 8'd37);
    write_reg(RegRadix, 8'd63);
    cfg_release();
    send_byte(8'hFF);
    send_text("00zZ-");
    send_text("-");
    send_text("zzzzzzzzzzzzzzzz!");
    wait_idle();
  endtask

  // each fill mode, letter case and sign overlap
  task automatic test_sign_and_fill_cases();
    load_config(CharPlus, CharMinus, CharSpace, ByteW'(RadixMin), ByteW'(FillRight),
                ByteW'(CaseLower));
    send_text("-1012 ");
    wait_idle();
    load_config(CharPlus, CharMinus, CharSpace, 8'd16, ByteW'(FillInternal),
                ByteW'(CaseUpper));
    send_text("fF-  f");
    wait_idle();
    load_config(CharPlus, CharMinus, CharSpace, 8'd16, ByteW'(FillSpare), ByteW'(CaseSpare));
    send_text(" Ab");
    wait_idle();
    // fill matching a sign character wins in a fill phase
    load_config(CharPlus, CharMinus, CharPlus, ByteW'(RadixDec), ByteW'(FillLeft),
                ByteW'(CaseEither));
    send_text("++5;");
    wait_idle();
    load_config(CharPlus, CharMinus, CharMinus, ByteW'(RadixDec), ByteW'(FillInternal),
                ByteW'(CaseEither));
    send_text("--7;");
    wait_idle();
  endtask

  // results held back long enough for the input side to stall
  task automatic test_backpressure();
    idle_on = 1'b0;
    load_config(CharPlus, CharMinus, CharSpace, ByteW'(RadixDec), ByteW'(FillLeft),
                ByteW'(CaseEither));
    hold_results = 1'b1;
    repeat (24) send_text("7,");
    wait_idle();
    idle_on = 1'b1;
  endtask

  // a long fill run before a short number
  task automatic test_long_fill();
    idle_on = 1'b0;
    repeat (40) send_byte(CharSpace);
    send_text("3.");
    wait_idle();
    idle_on = 1'b1;
  endtask

  // random settings, mostly well-formed numbers with some noise
  task automatic test_random_configs();
    int unsigned sent;
    int unsigned got;
    logic [ByteW-1:0] radix_w;
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) idle_on = 1'b0;
      wait_idle();
      if (p == 0) radix_w = ByteW'(RadixMin);
      else if (p == 1) radix_w = ByteW'(RadixMax);
      else if ($urandom_range(0, 7) == 0) radix_w = ByteW'($urandom_range(0, 255));
      else radix_w = ByteW'($urandom_range(RadixMin, RadixMax));
      write_reg(RegPlus, ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(0, 255)) : CharPlus);
      write_reg(RegMinus, ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(0, 255)) : CharMinus);
      case ($urandom_range(0, 2))
        0:       write_reg(RegFill, CharSpace);
        1:       write_reg(RegFill, 8'h00);
        default: write_reg(RegFill, ByteW'($urandom_range(0, 255)));
      endcase
      write_reg(RegRadix, radix_w);
      write_reg(RegFillMd, ($urandom_range(0, 7) == 0) ? ByteW'($urandom_range(0, 255))
                                                      : ByteW'($urandom_range(0, 3)));
      write_reg(RegCase, ($urandom_range(0, 7) == 0) ? ByteW'($urandom_range(0, 255))
                                                    : ByteW'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) write_reg(RegSpareLo, ByteW'($urandom_range(0, 255)));
      cfg_release();
      sent = 0;
      while (sent < 90) begin
        if ($urandom_range(0, 6) == 0) begin
          send_byte(ByteW'($urandom_range(0, 255)));
          sent++;
        end else begin
          send_number(got);
          sent += got;
        end
      end
    end
    wait_idle();
  endtask

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_parses.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d count %0d end %02h",
                                  parsed_value_o, bytes_consumed_o, end_byte_o));
      end else begin
        head_parse = expected_parses.pop_front();
        if (parsed_value_o !== head_parse.value)
          report_mismatch($sformatf("value %0d, want %0d", parsed_value_o, head_parse.value));
        if (bytes_consumed_o !== head_parse.count)
          report_mismatch($sformatf("count %0d, want %0d", bytes_consumed_o, head_parse.count));
        if (end_byte_o !== head_parse.term)
          report_mismatch($sformatf("end byte %02h, want %02h", end_byte_o, head_parse.term));
      end
    end
  end

  // result side ready, random stalls and the long hold
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main_flow
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_sign_and_fill_cases();
    test_backpressure();
    test_long_fill();
    test_random_configs();
    // drain whatever is still on its way
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_parses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_parses.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_parses.size()));
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
